[hw/rtl/tty_canonical_line_editor_defines.svh]
// Assertion macros for the terminal line editor checker.
// Used by tle_checker.sv; expects clk and arst_n in the scope of each use.
`ifndef TTY_CANONICAL_LINE_EDITOR_DEFINES_SVH
`define TTY_CANONICAL_LINE_EDITOR_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define TLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`endif

[hw/rtl/tle_pkg.sv]
// Shared types and constants of the terminal line editor.
// No dependencies; imported by every module of the block but tle_fifo and tle_checker.
package tle_pkg;

	localparam int LINE_CAP    = 32;
	localparam int MAX_OFFSETS = 32;
	localparam int LIMIT_CAP   = (LINE_CAP < MAX_OFFSETS) ? LINE_CAP : MAX_OFFSETS;

	localparam logic [7:0] CH_NL  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;

	localparam logic [7:0] DEF_INTR  = 8'd3;
	localparam logic [7:0] DEF_QUIT  = 8'd28;
	localparam logic [7:0] DEF_ERASE = 8'h08;
	localparam logic [7:0] DEF_KILL  = 8'h40;
	localparam logic [7:0] DEF_EOF   = 8'd4;

	localparam logic [4:0] RST_LFLAGS = 5'd31;
	localparam logic [4:0] RST_TFLAGS = 5'd26;
	localparam logic [5:0] RST_LIMIT  = 6'd32;

	// local flag bits
	localparam int LF_ISIG   = 0;
	localparam int LF_ICANON = 1;
	localparam int LF_ECHO   = 2;
	localparam int LF_ECHOE  = 3;
	localparam int LF_ECHOK  = 4;

	// translate flag bits
	localparam int TF_IGNCR = 0;
	localparam int TF_ICRNL = 1;
	localparam int TF_INLCR = 2;
	localparam int TF_OPOST = 3;
	localparam int TF_ONLCR = 4;

	localparam logic [1:0] SIG_NONE = 2'd0;
	localparam logic [1:0] SIG_INTR = 2'd1;
	localparam logic [1:0] SIG_QUIT = 2'd2;

	typedef enum logic [2:0] {
		REG_LFLAGS = 3'd0,
		REG_TFLAGS = 3'd1,
		REG_INTR   = 3'd2,
		REG_QUIT   = 3'd3,
		REG_ERASE  = 3'd4,
		REG_KILL   = 3'd5,
		REG_EOF    = 3'd6,
		REG_LIMIT  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [4:0] lflags;
		logic [4:0] tflags;
		logic [7:0] intr_ch;
		logic [7:0] quit_ch;
		logic [7:0] erase_ch;
		logic [7:0] kill_ch;
		logic [7:0] eof_ch;
		logic [5:0] limit;
	} cfg_t;

	typedef enum logic [2:0] {
		CMD_NOP   = 3'd0,
		CMD_INTR  = 3'd1,
		CMD_QUIT  = 3'd2,
		CMD_ERASE = 3'd3,
		CMD_KILL  = 3'd4,
		CMD_EOF   = 3'd5,
		CMD_STORE = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic [7:0] echo_a;
		logic [7:0] echo_b;
		logic [7:0] echo_c;
		logic [1:0] echo_cnt;
		logic       store_valid;
		logic [4:0] store_offset;
		logic [7:0] store_byte;
		logic [1:0] signal_code;
		logic       read_done;
		logic [5:0] read_length;
		logic       last;
	} res_t;

endpackage

[hw/rtl/tle_cfg.sv]
// Configuration register file of the terminal line editor.
// Depends on tle_pkg.
module tle_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [7:0]         wr_data,
	output tle_pkg::cfg_t      cfg
);
	import tle_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lflags   <= RST_LFLAGS;
			cfg_q.tflags   <= RST_TFLAGS;
			cfg_q.intr_ch  <= DEF_INTR;
			cfg_q.quit_ch  <= DEF_QUIT;
			cfg_q.erase_ch <= DEF_ERASE;
			cfg_q.kill_ch  <= DEF_KILL;
			cfg_q.eof_ch   <= DEF_EOF;
			cfg_q.limit    <= RST_LIMIT;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_LFLAGS: cfg_q.lflags   <= wr_data[4:0];
				REG_TFLAGS: cfg_q.tflags   <= wr_data[4:0];
				REG_INTR:   cfg_q.intr_ch  <= wr_data;
				REG_QUIT:   cfg_q.quit_ch  <= wr_data;
				REG_ERASE:  cfg_q.erase_ch <= wr_data;
				REG_KILL:   cfg_q.kill_ch  <= wr_data;
				REG_EOF:    cfg_q.eof_ch   <= wr_data;
				REG_LIMIT:  cfg_q.limit    <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/tle_front.sv]
// Front end: CR/NL translation and classification of one received character.
// Depends on tle_pkg; feeds the command queue.
module tle_front (
	input  tle_pkg::cfg_t cfg,
	input  logic [7:0]    in_char,
	output tle_pkg::cmd_t cmd
);
	import tle_pkg::*;

	function automatic logic [7:0] pick(input logic [7:0] r, input logic [7:0] d);
		return (r != 8'd0) ? r : d;
	endfunction

	logic [7:0] ch;
	logic       isig;
	logic       canon;

	assign isig  = cfg.lflags[LF_ISIG];
	assign canon = cfg.lflags[LF_ICANON];

	always_comb begin
		ch = in_char;
		if (cfg.tflags[TF_ICRNL]) begin
			if (in_char == CH_CR) ch = CH_NL;
		end else if (cfg.tflags[TF_INLCR]) begin
			if (in_char == CH_NL) ch = CH_CR;
		end
	end

	always_comb begin
		cmd.ch = ch;
		if (cfg.tflags[TF_IGNCR] && in_char == CH_CR)
			cmd.kind = CMD_NOP;
		else if (isig && ch == pick(cfg.intr_ch, DEF_INTR))
			cmd.kind = CMD_INTR;
		else if (isig && ch == pick(cfg.quit_ch, DEF_QUIT))
			cmd.kind = CMD_QUIT;
		else if (canon && (ch == pick(cfg.erase_ch, DEF_ERASE) || ch == CH_DEL))
			cmd.kind = CMD_ERASE;
		else if (canon && ch == pick(cfg.kill_ch, DEF_KILL))
			cmd.kind = CMD_KILL;
		else if (canon && ch == pick(cfg.eof_ch, DEF_EOF))
			cmd.kind = CMD_EOF;
		else
			cmd.kind = CMD_STORE;
	end

endmodule

[hw/rtl/tle_fifo.sv]
// Small first-in first-out queue of fixed-width words.
// No package dependency; used for the command queue and the result queue.
module tle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= bump(wr_ptr_q);
			if (do_rd) rd_ptr_q <= bump(rd_ptr_q);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hw/rtl/tle_back.sv]
// Back end: line position, editing sequencer and result formatting.
// Depends on tle_pkg; reads the command queue, writes the result queue.
module tle_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tle_pkg::cfg_t cfg,
	input  tle_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output tle_pkg::res_t res
);
	import tle_pkg::*;

	typedef enum logic [2:0] {
		ST_RUN  = 3'b001,
		ST_KILL = 3'b010,
		ST_KNL  = 3'b100
	} bstate_t;

	bstate_t    state_q, state_d;
	logic [4:0] pos_q, pos_d;
	logic [5:0] pos_inc;
	logic [5:0] lim;
	logic       echo;
	logic       visual;
	logic       nl_en;
	logic       canon;
	logic       st_done;

	assign echo   = cfg.lflags[LF_ECHO];
	assign visual = cfg.lflags[LF_ECHOE];
	assign canon  = cfg.lflags[LF_ICANON];
	assign nl_en  = echo && cfg.lflags[LF_ECHOK];

	assign pos_inc = {1'b0, pos_q} + 6'd1;

	always_comb begin
		if (cfg.limit == 6'd0)
			lim = 6'd1;
		else if (cfg.limit > 6'(LIMIT_CAP))
			lim = 6'(LIMIT_CAP);
		else
			lim = cfg.limit;
	end

	assign st_done = !canon || cmd.ch == CH_NL || pos_inc >= lim;

	function automatic res_t rubout(input logic e, input logic v, input logic lst);
		res_t r;
		r = '0;
		if (e && v) begin
			r.echo_a   = CH_BS;
			r.echo_b   = CH_SP;
			r.echo_c   = CH_BS;
			r.echo_cnt = 2'd3;
		end else if (e) begin
			r.echo_a   = CH_BS;
			r.echo_cnt = 2'd1;
		end
		r.last = lst;
		return r;
	endfunction

	function automatic res_t kill_nl();
		res_t r;
		r = '0;
		r.echo_a   = CH_NL;
		r.echo_cnt = 2'd1;
		r.last     = 1'b1;
		return r;
	endfunction

	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res      = '0;
		case (state_q)
			ST_RUN: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop  = 1'b1;
					res_push = 1'b1;
					res.last = 1'b1;
					case (cmd.kind)
						CMD_INTR: res.signal_code = SIG_INTR;
						CMD_QUIT: res.signal_code = SIG_QUIT;
						CMD_ERASE: begin
							if (pos_q != 5'd0) begin
								pos_d = pos_q - 5'd1;
								res   = rubout(echo, visual, 1'b1);
							end
						end
						CMD_KILL: begin
							if (pos_q != 5'd0) begin
								pos_d = pos_q - 5'd1;
								res   = rubout(echo, visual, pos_q == 5'd1 && !nl_en);
								if (pos_q != 5'd1)
									state_d = ST_KILL;
								else if (nl_en)
									state_d = ST_KNL;
							end else if (nl_en) begin
								res = kill_nl();
							end
						end
						CMD_EOF: begin
							res.read_done   = 1'b1;
							res.read_length = {1'b0, pos_q};
							pos_d           = 5'd0;
						end
						CMD_STORE: begin
							if (echo) begin
								if (cmd.ch == CH_NL && cfg.tflags[TF_OPOST]
									&& cfg.tflags[TF_ONLCR]) begin
									res.echo_a   = CH_CR;
									res.echo_b   = CH_NL;
									res.echo_cnt = 2'd2;
								end else begin
									res.echo_a   = cmd.ch;
									res.echo_cnt = 2'd1;
								end
							end
							res.store_valid  = 1'b1;
							res.store_offset = pos_q;
							res.store_byte   = cmd.ch;
							if (st_done) begin
								res.read_done   = 1'b1;
								res.read_length = pos_inc;
								pos_d           = 5'd0;
							end else begin
								pos_d = pos_inc[4:0];
							end
						end
						default: ;
					endcase
				end
			end
			ST_KILL: begin
				if (!res_full) begin
					res_push = 1'b1;
					pos_d    = pos_q - 5'd1;
					res      = rubout(echo, visual, pos_q == 5'd1 && !nl_en);
					if (pos_q == 5'd1) state_d = nl_en ? ST_KNL : ST_RUN;
				end
			end
			ST_KNL: begin
				if (!res_full) begin
					res_push = 1'b1;
					res      = kill_nl();
					state_d  = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			pos_q   <= 5'd0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
		end
	end

endmodule

[hw/rtl/tty_canonical_line_editor.sv]
// Channel  | Handshake               | Beat
// input    | push / full             | in_char
// result   | empty / pop             | echo bytes, store, signal, read status, last
// config   | cfg_wr_en, cfg_index    | cfg_data, taken at once
//
// A character passes the front end in the cycle it is pushed and waits in the
// command queue; the back end makes one result beat per cycle while the result
// queue has room. Most characters give one beat. A kill gives one beat per stored
// character plus an optional newline beat, or one empty beat if it has neither,
// paced by the back end sequencer. Reset clears the queues and the line position
// and returns the registers to their defaults.
// A full result queue stalls the back end; a full command queue raises full.
// Depends on tle_pkg, tle_cfg, tle_front, tle_fifo and tle_back.
module tty_canonical_line_editor #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] echo_byte_a,
	output logic [7:0] echo_byte_b,
	output logic [7:0] echo_byte_c,
	output logic [1:0] echo_count,
	output logic       store_valid,
	output logic [4:0] store_offset,
	output logic [7:0] store_byte,
	output logic [1:0] signal_code,
	output logic       read_done,
	output logic [5:0] read_length,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import tle_pkg::*;

	cfg_t cfg;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	res_t res_in;
	res_t res_out;
	logic res_full;
	logic res_push;

	tle_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tle_front u_front (
		.cfg     (cfg),
		.in_char (in_char),
		.cmd     (cmd_in)
	);

	tle_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	assign full = cmd_full;

	tle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	tle_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_out),
		.full    (res_full),
		.empty   (empty)
	);

	assign echo_byte_a  = res_out.echo_a;
	assign echo_byte_b  = res_out.echo_b;
	assign echo_byte_c  = res_out.echo_c;
	assign echo_count   = res_out.echo_cnt;
	assign store_valid  = res_out.store_valid;
	assign store_offset = res_out.store_offset;
	assign store_byte   = res_out.store_byte;
	assign signal_code  = res_out.signal_code;
	assign read_done    = res_out.read_done;
	assign read_length  = res_out.read_length;
	assign last         = res_out.last;

endmodule

[hw/rtl/tle_checker.sv]
// Port-level checks on the result queue of the terminal line editor.
// Depends on tty_canonical_line_editor_defines.svh; bound to the top level.
`include "tty_canonical_line_editor_defines.svh"

module tle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] echo_byte_a,
	input logic [1:0] echo_count,
	input logic       store_valid,
	input logic [4:0] store_offset,
	input logic [7:0] store_byte,
	input logic [1:0] signal_code,
	input logic       read_done,
	input logic [5:0] read_length,
	input logic       last
);

	// hold a waiting beat until it is popped
	`TLE_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(store_byte) && $stable(echo_byte_a) && $stable(last), "result beat changed while stalled")

	`TLE_ASSERT_NOW(a_sig_alone, !empty && signal_code != 2'd0, echo_count == 2'd0 && !store_valid && !read_done && last, "signal beat carries other content")

	`TLE_ASSERT_NOW(a_len_match, !empty && read_done && store_valid, read_length == (6'(store_offset) + 6'd1), "read length does not follow the final offset")

	`TLE_ASSERT_NOW(a_no_store, !empty && !store_valid, store_offset == 5'd0 && store_byte == 8'd0, "store fields set without a stored character")

endmodule

bind tty_canonical_line_editor tle_checker u_tle_checker (.*);

[tb/sv/tle_line_checker.sv]
// Checker for the terminal line editor: watches the input, config and result channels,
// predicts the result beats of every accepted character and compares them field by field.
// Depends on tle_pkg for the result layout, flag bit positions and default control characters.
module tle_line_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] in_char,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] echo_byte_a,
	input  logic [7:0] echo_byte_b,
	input  logic [7:0] echo_byte_c,
	input  logic [1:0] echo_count,
	input  logic       store_valid,
	input  logic [4:0] store_offset,
	input  logic [7:0] store_byte,
	input  logic [1:0] signal_code,
	input  logic       read_done,
	input  logic [5:0] read_length,
	input  logic       last,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending
);
	import tle_pkg::*;

	res_t       editor_beats[$];
	res_t       want;
	logic [4:0] lflags;
	logic [4:0] tflags;
	logic [7:0] intr_ch;
	logic [7:0] quit_ch;
	logic [7:0] erase_ch;
	logic [7:0] kill_ch;
	logic [7:0] eof_ch;
	logic [5:0] limit;
	logic [5:0] line_pos;

	function automatic logic [7:0] pick(input logic [7:0] value, input logic [7:0] dflt);
		return (value != 8'd0) ? value : dflt;
	endfunction

	function automatic res_t rubout(input logic echo, input logic visual);
		res_t r;
		r = '0;
		if (echo && visual) begin
			r.echo_a   = CH_BS;
			r.echo_b   = CH_SP;
			r.echo_c   = CH_BS;
			r.echo_cnt = 2'd3;
		end else if (echo) begin
			r.echo_a   = CH_BS;
			r.echo_cnt = 2'd1;
		end
		return r;
	endfunction

	task automatic edit_char(input logic [7:0] raw);
		logic [7:0] c;
		logic [5:0] lim;
		res_t       r;
		logic       isig, canon, echo, visual, echok;
		int         first;
		c      = raw;
		first  = editor_beats.size();
		isig   = lflags[LF_ISIG];
		canon  = lflags[LF_ICANON];
		echo   = lflags[LF_ECHO];
		visual = lflags[LF_ECHOE];
		echok  = lflags[LF_ECHOK];
		lim    = (limit == 6'd0) ? 6'd1 : limit;
		if (lim > 6'(LIMIT_CAP))
			lim = 6'(LIMIT_CAP);
		if (line_pos > 6'd31)
			line_pos = '0;
		r = '0;
		if (tflags[TF_IGNCR] && c == CH_CR) begin
			editor_beats.push_back(r);
		end else begin
			if (tflags[TF_ICRNL]) begin
				if (c == CH_CR)
					c = CH_NL;
			end else if (tflags[TF_INLCR] && c == CH_NL) begin
				c = CH_CR;
			end

			if (isig && c == pick(intr_ch, DEF_INTR)) begin
				r.signal_code = SIG_INTR;
				editor_beats.push_back(r);
			end else if (isig && c == pick(quit_ch, DEF_QUIT)) begin
				r.signal_code = SIG_QUIT;
				editor_beats.push_back(r);
			end else if (canon && (c == pick(erase_ch, DEF_ERASE) || c == CH_DEL)) begin
				if (line_pos > 6'd0) begin
					line_pos = line_pos - 6'd1;
					r = rubout(echo, visual);
				end
				editor_beats.push_back(r);
			end else if (canon && c == pick(kill_ch, DEF_KILL)) begin
				// one rubout beat per stored character, then the optional newline
				while (line_pos > 6'd0) begin
					line_pos = line_pos - 6'd1;
					editor_beats.push_back(rubout(echo, visual));
				end
				if (echo && echok) begin
					r.echo_a   = CH_NL;
					r.echo_cnt = 2'd1;
					editor_beats.push_back(r);
				end else if (editor_beats.size() == first) begin
					editor_beats.push_back(r);
				end
			end else if (canon && c == pick(eof_ch, DEF_EOF)) begin
				r.read_done   = 1'b1;
				r.read_length = line_pos;
				line_pos      = '0;
				editor_beats.push_back(r);
			end else begin
				if (echo) begin
					if (c == CH_NL && tflags[TF_OPOST] && tflags[TF_ONLCR]) begin
						r.echo_a   = CH_CR;
						r.echo_b   = CH_NL;
						r.echo_cnt = 2'd2;
					end else begin
						r.echo_a   = c;
						r.echo_cnt = 2'd1;
					end
				end
				r.store_valid  = 1'b1;
				r.store_offset = line_pos[4:0];
				r.store_byte   = c;
				line_pos       = line_pos + 6'd1;
				if (!canon || c == CH_NL || line_pos >= lim) begin
					r.read_done   = 1'b1;
					r.read_length = line_pos;
					line_pos      = '0;
				end
				editor_beats.push_back(r);
			end
		end
		// mark the final beat of this character
		r = editor_beats.pop_back();
		r.last = 1'b1;
		editor_beats.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			editor_beats.delete();
			fail_count = 0;
			pending    = 0;
			lflags     = RST_LFLAGS;
			tflags     = RST_TFLAGS;
			intr_ch    = DEF_INTR;
			quit_ch    = DEF_QUIT;
			erase_ch   = DEF_ERASE;
			kill_ch    = DEF_KILL;
			eof_ch     = DEF_EOF;
			limit      = RST_LIMIT;
			line_pos   = '0;
		end else begin
			if (pop && !empty) begin
				if (editor_beats.size() == 0) begin
					$error("result beat with no expected beat waiting");
					fail_count++;
				end else begin
					want = editor_beats.pop_front();
					check_field("echo_byte_a", want.echo_a, echo_byte_a);
					check_field("echo_byte_b", want.echo_b, echo_byte_b);
					check_field("echo_byte_c", want.echo_c, echo_byte_c);
					check_field("echo_count", 8'(want.echo_cnt), 8'(echo_count));
					check_field("store_valid", 8'(want.store_valid), 8'(store_valid));
					check_field("store_offset", 8'(want.store_offset), 8'(store_offset));
					check_field("store_byte", want.store_byte, store_byte);
					check_field("signal_code", 8'(want.signal_code), 8'(signal_code));
					check_field("read_done", 8'(want.read_done), 8'(read_done));
					check_field("read_length", 8'(want.read_length), 8'(read_length));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_LFLAGS: lflags   = cfg_data[4:0];
					REG_TFLAGS: tflags   = cfg_data[4:0];
					REG_INTR:   intr_ch  = cfg_data;
					REG_QUIT:   quit_ch  = cfg_data;
					REG_ERASE:  erase_ch = cfg_data;
					REG_KILL:   kill_ch  = cfg_data;
					REG_EOF:    eof_ch   = cfg_data;
					REG_LIMIT:  limit    = cfg_data[5:0];
					default: ;
				endcase
			end
			if (push && !full)
				edit_char(in_char);
			pending = editor_beats.size();
		end
	end

endmodule

[tb/sv/tb_tty_canonical_line_editor.sv]
// Top of the terminal line editor testbench: clock, reset, character and config stimulus,
// random result stalls, watchdog and verdict. Depends on tle_pkg and tle_line_checker.
module tb_tty_canonical_line_editor;
	import tle_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 28;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic [7:0] in_char   = 8'd0;
	logic       pop       = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = REG_LFLAGS;
	logic [7:0] cfg_data  = 8'd0;
	logic       full;
	logic       empty;
	logic [7:0] echo_byte_a;
	logic [7:0] echo_byte_b;
	logic [7:0] echo_byte_c;
	logic [1:0] echo_count;
	logic       store_valid;
	logic [4:0] store_offset;
	logic [7:0] store_byte;
	logic [1:0] signal_code;
	logic       read_done;
	logic [5:0] read_length;
	logic       last;
	int         fail_count;
	int         pending;
	int         quiet_cycles = 0;
	bit         steady       = 1'b0;

	// current control characters, kept to aim the random characters
	logic [7:0] cur_intr, cur_quit, cur_erase, cur_kill, cur_eof;

	tty_canonical_line_editor i_dut (.*);
	tle_line_checker i_checker (.*);

	always #2 clk = ~clk;

	always @(negedge clk)
		pop <= steady || ($urandom_range(99) >= 29);

	always @(posedge clk) begin
		if (arst_n && !((push && !full) || (pop && !empty))) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	task automatic send_char(input logic [7:0] ch);
		while (!steady && $urandom_range(99) < 29) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push    <= 1'b1;
		in_char <= ch;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
	endtask

	// drop push and hold until every expected beat has come back
	task automatic settle();
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(input logic [4:0] lf, input logic [4:0] tf,
			input logic [7:0] ic, input logic [7:0] qc, input logic [7:0] ec,
			input logic [7:0] kc, input logic [7:0] fc, input logic [5:0] lim);
		settle();
		write_reg(REG_LFLAGS, {3'd0, lf});
		write_reg(REG_TFLAGS, {3'd0, tf});
		write_reg(REG_INTR, ic);
		write_reg(REG_QUIT, qc);
		write_reg(REG_ERASE, ec);
		write_reg(REG_KILL, kc);
		write_reg(REG_EOF, fc);
		write_reg(REG_LIMIT, {2'd0, lim});
		cfg_wr_en <= 1'b0;
		cur_intr  = (ic != 8'd0) ? ic : DEF_INTR;
		cur_quit  = (qc != 8'd0) ? qc : DEF_QUIT;
		cur_erase = (ec != 8'd0) ? ec : DEF_ERASE;
		cur_kill  = (kc != 8'd0) ? kc : DEF_KILL;
		cur_eof   = (fc != 8'd0) ? fc : DEF_EOF;
	endtask

	function automatic logic [7:0] random_ctrl(input logic [7:0] dflt);
		case ($urandom_range(3))
			0:       return 8'd0;
			1:       return dflt;
			2:       return 8'($urandom_range(31, 1));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly typed lines with edits and line ends, some raw noise
	function automatic logic [7:0] random_char();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 8'($urandom_range(126, 32));
		else if (roll < 58)
			return cur_erase;
		else if (roll < 62)
			return CH_DEL;
		else if (roll < 66)
			return cur_kill;
		else if (roll < 73)
			return CH_NL;
		else if (roll < 78)
			return CH_CR;
		else if (roll < 82)
			return cur_eof;
		else if (roll < 85)
			return cur_intr;
		else if (roll < 88)
			return cur_quit;
		else
			return 8'($urandom_range(255));
	endfunction

	initial begin
		logic [4:0] lf;
		logic [5:0] lim;
		cur_intr  = DEF_INTR;
		cur_quit  = DEF_QUIT;
		cur_erase = DEF_ERASE;
		cur_kill  = DEF_KILL;
		cur_eof   = DEF_EOF;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: type, erase, kill, line ends, EOF, signals, byte extremes
		send_char(8'h61); send_char(8'h62); send_char(DEF_ERASE); send_char(8'h63);
		send_char(CH_DEL); send_char(8'h64); send_char(8'h65); send_char(DEF_KILL);
		send_char(DEF_ERASE); send_char(DEF_KILL); send_char(8'h78); send_char(CH_CR);
		send_char(8'h79); send_char(DEF_EOF); send_char(DEF_EOF); send_char(DEF_INTR);
		send_char(DEF_QUIT); send_char(8'h00); send_char(8'hff); send_char(CH_NL);

		// ignored CR, NL to CR, plain backspace kill without newline, quiet erase
		write_config(5'd7, 5'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd32);
		send_char(CH_CR); send_char(CH_NL); send_char(8'h7a); send_char(DEF_KILL);
		send_char(DEF_KILL);
		write_config(5'd3, 5'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd32);
		send_char(8'h71); send_char(DEF_ERASE);

		for (int p = 0; p < PHASES; p++) begin
			steady = (p == 6 || p == 7);
			if (p == 0) begin
				write_config(5'd0, 5'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd0);
			end else if (p == 1) begin
				write_config(5'd31, 5'd31, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 6'd32);
			end else if (p == 2) begin
				write_config(5'd31, 5'd26, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd1);
			end else begin
				lf = 5'($urandom_range(31));
				if ($urandom_range(3) != 0)
					lf[LF_ICANON] = 1'b1;
				case ($urandom_range(3))
					0:       lim = 6'd32;
					1:       lim = 6'($urandom_range(6, 1));
					default: lim = 6'($urandom_range(32, 1));
				endcase
				write_config(lf, 5'($urandom_range(31)), random_ctrl(DEF_INTR),
					random_ctrl(DEF_QUIT), random_ctrl(DEF_ERASE),
					random_ctrl(DEF_KILL), random_ctrl(DEF_EOF), lim);
			end
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_char(random_char());
		end
		steady = 1'b0;

		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/tle_pkg.sv
hw/rtl/tle_cfg.sv
hw/rtl/tle_front.sv
hw/rtl/tle_fifo.sv
hw/rtl/tle_back.sv
hw/rtl/tty_canonical_line_editor.sv
hw/rtl/tle_checker.sv
tb/sv/tle_line_checker.sv
tb/sv/tb_tty_canonical_line_editor.sv
